### rtl/core/ialu_pkg.sv
// Shared types and constants for the integer ALU pipeline.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package ialu_pkg;

    localparam int QUOTIENT_BITS_DEF = 8;
    localparam int DATA_W            = 32;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // Payload carried down the pipeline with each item
    typedef struct packed {
        cmd_t              cmd;
        logic [DATA_W-1:0] value;  // add/sub/mul result
        logic [DATA_W-1:0] rem;    // running partial remainder
        logic [DATA_W-1:0] den;    // divisor magnitude
        logic [DATA_W-1:0] quo;    // quotient bits found so far
        logic              neg;    // quotient to be negated
        logic              dz;     // divide by zero
    } stage_t;

endpackage

`default_nettype wire

### rtl/core/ialu_prep.sv
// Entry stage: decodes the command, does add/sub/multiply, forms divide magnitudes.
// Depends on ialu_pkg.
`default_nettype none

module ialu_prep
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire ialu_pkg::cmd_t                cmd,
    input  wire logic [ialu_pkg::DATA_W-1:0]   op_a,
    input  wire logic [ialu_pkg::DATA_W-1:0]   op_b,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output ialu_pkg::stage_t                   out_data
);

    logic                             valid_reg;
    ialu_pkg::stage_t                 data_reg;
    ialu_pkg::stage_t                 data_next;
    logic [ialu_pkg::DATA_W-1:0]      mag_a;
    logic [ialu_pkg::DATA_W-1:0]      mag_b;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // the most negative value keeps its pattern, read as unsigned 2^31
    assign mag_a = op_a[ialu_pkg::DATA_W-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[ialu_pkg::DATA_W-1] ? (~op_b + 1'b1) : op_b;

    always_comb
    begin
        data_next     = '0;
        data_next.cmd = cmd;
        data_next.rem = mag_a;
        data_next.den = mag_b;
        data_next.quo = '0;
        data_next.neg = op_a[ialu_pkg::DATA_W-1] ^ op_b[ialu_pkg::DATA_W-1];
        data_next.dz  = 1'b0;
        case (cmd)
            ialu_pkg::CMD_ADD: data_next.value = op_a + op_b;
            ialu_pkg::CMD_SUB: data_next.value = op_a - op_b;
            ialu_pkg::CMD_MUL: data_next.value = op_a * op_b;
            ialu_pkg::CMD_DIV:
            begin
                data_next.value = '0;
                data_next.dz    = (op_b == '0);
            end
            default:           data_next.value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ialu_div_step.sv
// One restoring-division stage: tries quotient bit BIT and registers the result.
// Depends on ialu_pkg.
`default_nettype none

module ialu_div_step
#(
    parameter int BIT = 0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ialu_pkg::stage_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ialu_pkg::stage_t       out_data
);

    localparam logic [ialu_pkg::DATA_W-1:0] LOW_MASK =
        ialu_pkg::DATA_W'((64'd1 << BIT) - 64'd1);

    logic                         valid_reg;
    ialu_pkg::stage_t             data_reg;
    ialu_pkg::stage_t             data_next;
    logic [ialu_pkg::DATA_W-1:0]  rem_hi;
    logic [ialu_pkg::DATA_W:0]    diff;
    logic                         fits;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // (rem >> BIT) >= den, and rem - (den << BIT) only touches bit BIT and the bits above it
    assign rem_hi = in_data.rem >> BIT;
    assign diff   = {1'b0, rem_hi} - {1'b0, in_data.den};
    assign fits   = !diff[ialu_pkg::DATA_W];

    always_comb
    begin
        data_next = in_data;
        if (fits)
        begin
            data_next.rem      = (diff[ialu_pkg::DATA_W-1:0] << BIT) | (in_data.rem & LOW_MASK);
            data_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ialu_out.sv
// Output stage: applies the quotient sign, selects the result, holds the output item.
// Depends on ialu_pkg.
`default_nettype none

module ialu_out
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire ialu_pkg::stage_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ialu_pkg::DATA_W-1:0]        result,
    output logic                               dz
);

    logic                         valid_reg;
    logic [ialu_pkg::DATA_W-1:0]  result_reg;
    logic [ialu_pkg::DATA_W-1:0]  result_next;
    logic                         dz_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;
    assign dz        = dz_reg;

    always_comb
    begin
        case (in_data.cmd)
            ialu_pkg::CMD_DIV: result_next = in_data.neg ? (~in_data.quo + 1'b1) : in_data.quo;
            default:           result_next = in_data.value;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= result_next;
            dz_reg     <= in_data.dz;
        end
    end

endmodule

`default_nettype wire

### rtl/core/integer_alu_add_sub_mul_div_top.sv
// Integer ALU top level: add, subtract, multiply (low 32 bits), restoring divide.
// Pipeline: entry stage, one stage per quotient bit, output stage.
// Throughput one item per cycle unless stalled; stages hold items under back-pressure and
// bubbles close up, so input is taken while a result waits if any stage is empty.
// Reset (rst_n low, asynchronous) empties every stage; no item is lost on a stall.
// Depends on ialu_pkg, ialu_prep, ialu_div_step, ialu_out.
`default_nettype none

module integer_alu_add_sub_mul_div_top
#(
    parameter int QUOTIENT_BITS = ialu_pkg::QUOTIENT_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] result
    output logic             m_tuser    // [0] divide_by_zero
);

    localparam int NBITS = (QUOTIENT_BITS > 32) ? 32 : QUOTIENT_BITS;
    localparam logic [ialu_pkg::DATA_W-1:0] QMASK =
        ialu_pkg::DATA_W'((64'd1 << NBITS) - 64'd1);

    ialu_pkg::stage_t  pipe  [0:NBITS];
    logic              valid [0:NBITS];
    logic              ready [0:NBITS];

    ialu_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (ialu_pkg::cmd_t'(s_tuser)),
        .op_a      (s_tdata[31:0]),
        .op_b      (s_tdata[63:32]),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .out_data  (pipe[0])
    );

    // stage k tries quotient bit NBITS-1-k, top bit first
    for (genvar k = 0; k < NBITS; k++)
    begin : g_step
        ialu_div_step
        #(
            .BIT (NBITS - 1 - k)
        )
        u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[k]),
            .in_ready  (ready[k]),
            .in_data   (pipe[k]),
            .out_valid (valid[k+1]),
            .out_ready (ready[k+1]),
            .out_data  (pipe[k+1])
        );
    end

    ialu_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid[NBITS]),
        .in_ready  (ready[NBITS]),
        .in_data   (pipe[NBITS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (m_tdata),
        .dz        (m_tuser)
    );

    // an empty or draining output stage frees the whole chain
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output stage can move");

    // a zero divisor must leave every quotient step taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid[NBITS] && pipe[NBITS].dz) |-> (pipe[NBITS].quo == QMASK))
        else $error("zero divisor quotient not all ones");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid[NBITS] && pipe[NBITS].dz) |->
            (pipe[NBITS].cmd == ialu_pkg::CMD_DIV && pipe[NBITS].den == '0))
        else $error("divide-by-zero flag on non-zero divisor");

    // quotient never gains bits above the configured width
    assert property (@(posedge clk) disable iff (!rst_n)
        valid[NBITS] |-> ((pipe[NBITS].quo & ~QMASK) == '0))
        else $error("quotient bit outside range");

endmodule

`default_nettype wire
